// ===== design/sch_pkg.sv =====
`timescale 1ns / 1ps

package sch_pkg;

    // Field widths of one reading and one result.
    localparam int BOARD_W = 1;
    localparam int CHAN_W  = 2;
    localparam int CUR_W   = 19;
    localparam int VOLT_W  = 13;
    localparam int VAL_W   = 21;
    localparam int INCH_W  = 17;

    // Fixed-point grid of currents, voltages and results.
    localparam int FRAC_BITS = 8;
    localparam int ONE_FX    = 1 << FRAC_BITS;

    // Health status codes.
    localparam logic [1:0] ST_GOOD    = 2'd0;
    localparam logic [1:0] ST_ONE     = 2'd1;
    localparam logic [1:0] ST_TWO     = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // Channel codes.
    localparam logic [CHAN_W-1:0] CH_0 = 2'd0;
    localparam logic [CHAN_W-1:0] CH_1 = 2'd1;
    localparam logic [CHAN_W-1:0] CH_2 = 2'd2;
    localparam logic [CHAN_W-1:0] CH_3 = 2'd3;

    // Switch windows (current, mA).
    localparam int SW_LOW      = ONE_FX;
    localparam int SW_HIGH     = 29 * ONE_FX;
    localparam int SW_CLOSED   = 15 * ONE_FX;
    localparam int SW_B_FAULT  = (14 * ONE_FX) / 10;       // at or below 1.4 mA
    localparam int SW_B_LOW    = (3 * ONE_FX + 1) / 2;     // at or above 1.5 mA
    localparam int SW_OPEN_VAL = 255 * ONE_FX;

    // Pressure sensor (voltage, V).
    localparam int PSI_LOW  = ONE_FX;
    localparam int PSI_HIGH = (9 * ONE_FX) / 2;            // above 4.5 V

    // Supply rails.
    localparam int R33_LOW    = (31 * ONE_FX + 9) / 10;    // below 3.1 V
    localparam int R33_HIGH   = (7 * ONE_FX) / 2;          // above 3.5 V
    localparam int R12_LOW    = 9 * ONE_FX;
    localparam int R12_HIGH   = 15 * ONE_FX;
    localparam int R12_I_HIGH = 500 * ONE_FX;

    // Water level loop (current, mA).
    localparam int WL_LOW     = (7 * ONE_FX + 1) / 2;      // below 3.5 mA
    localparam int WL_HIGH    = 21 * ONE_FX;
    localparam int WL_MARK_LO = 255 * ONE_FX;
    localparam int WL_MARK_HI = -ONE_FX;

    // Depth in mm is trunc((WL_MUL * I - WL_OFF) / 3616), the ratio
    // 2940 / 15.82 with common factors removed. The division is done as a
    // shift by 5 and an exact reciprocal of 113 over 19-bit operands.
    localparam int NUM_W        = 26;
    localparam int WL_MUL       = 2625;
    localparam int WL_OFF       = 2538240;
    localparam int MM_PRE_SHIFT = 5;
    localparam int MM_OP_W      = 19;
    localparam int MM_RECIP     = 593884;
    localparam int MM_RECIP_W   = 20;
    localparam int MM_SHIFT     = 26;
    localparam int MM_W         = 12;

    // Inches = trunc(mm * 1280 / 127), again by an exact reciprocal.
    localparam int IN_X_W      = 22;
    localparam int IN_RECIP    = 4227331;
    localparam int IN_RECIP_W  = 23;
    localparam int IN_SHIFT    = 29;
    localparam int IN_MAG_W    = 15;

endpackage

// ===== design/sensor_channel_health_and_scaling.sv =====
`timescale 1ns / 1ps

// Sensor channel health and scaling.
// Input channel: i_valid / o_ready with board, channel, shunt current and bus
// voltage, currents and voltages in fixed point with 8 fraction bits. Each
// transaction produces exactly one result transaction on o_valid / i_ready:
// a health status, a flag for whether a value is written, the scaled value
// (switch code, whole-mA current, psi or depth in mm) and depth in inches.
// The datapath is a four-register pipeline: input register, classification
// and loop numerator, depth in mm (reciprocal multiply), depth in inches and
// result register. One transaction per cycle is sustained while the receiver
// holds i_ready high; the two reciprocal multipliers set the stage count.
// Reset empties the pipeline; o_valid is low and o_ready is high after it.
// When the receiver holds i_ready low, the result register holds its
// transaction, empty stages behind it keep filling, and o_ready falls only
// once all four stages hold transactions.

module sensor_channel_health_and_scaling (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [sch_pkg::BOARD_W-1:0]       i_board_index,
    input  logic [sch_pkg::CHAN_W-1:0]        i_channel_index,
    input  logic signed [sch_pkg::CUR_W-1:0]  i_current_reading,
    input  logic [sch_pkg::VOLT_W-1:0]        i_bus_voltage,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_health_status,
    output logic                              o_value_written,
    output logic signed [sch_pkg::VAL_W-1:0]  o_scaled_value,
    output logic signed [sch_pkg::INCH_W-1:0] o_depth_inches
);
    import sch_pkg::*;

    localparam int CI_W = CUR_W - FRAC_BITS;

    // Pipeline occupancy and advance enables.
    logic r_v0, r_v1, r_v2, r_v3;
    logic w_en0, w_en1, w_en2, w_en3;

    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign w_en0   = !r_v0 || w_en1;
    assign o_ready = w_en0;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en0) r_v0 <= i_valid;
            if (w_en1) r_v1 <= r_v0;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    // Stage 0: input register.
    logic [BOARD_W-1:0]       r_s0_board;
    logic [CHAN_W-1:0]        r_s0_chan;
    logic signed [CUR_W-1:0]  r_s0_cur;
    logic [VOLT_W-1:0]        r_s0_volt;

    always_ff @(posedge i_clk) begin
        if (w_en0) begin
            r_s0_board <= i_board_index;
            r_s0_chan  <= i_channel_index;
            r_s0_cur   <= i_current_reading;
            r_s0_volt  <= i_bus_voltage;
        end
    end

    // Stage 1: classification, direct values and the water loop numerator.
    logic signed [CI_W-1:0]   w_cur_int;
    logic                     w_cur_adj;
    logic signed [CI_W-1:0]   w_cur_tz;
    logic signed [VAL_W-1:0]  w_cur_whole;
    logic signed [VAL_W-1:0]  w_sw_code;
    logic [VOLT_W:0]          w_twice;
    logic [VOLT_W+4:0]        w_psi_x15;
    logic [NUM_W-2:0]         w_prod;
    logic signed [NUM_W-1:0]  w_num;

    logic [1:0]               n_s1_status;
    logic                     n_s1_written;
    logic signed [VAL_W-1:0]  n_s1_val;
    logic signed [INCH_W-1:0] n_s1_inch;
    logic                     n_s1_water;

    // Whole mA, truncated toward zero.
    assign w_cur_int   = CI_W'(r_s0_cur >>> FRAC_BITS);
    assign w_cur_adj   = r_s0_cur[CUR_W-1] && (|r_s0_cur[FRAC_BITS-1:0]);
    assign w_cur_tz    = w_cur_int + $signed({{(CI_W-1){1'b0}}, w_cur_adj});
    assign w_cur_whole = VAL_W'($signed({w_cur_tz, {FRAC_BITS{1'b0}}}));
    assign w_sw_code   = (r_s0_cur < SW_CLOSED) ? '0 : VAL_W'(ONE_FX);

    // psi = (2V - 1) * 15 / 4 on the fraction grid.
    assign w_twice   = {r_s0_volt, 1'b0} - (VOLT_W+1)'(ONE_FX);
    assign w_psi_x15 = ((VOLT_W+5)'(w_twice) << 4) - (VOLT_W+5)'(w_twice);

    // Only meaningful when the loop current is in range, where it is
    // positive and below 2^13.
    assign w_prod = (NUM_W-1)'(r_s0_cur[12:0]) * (NUM_W-1)'(WL_MUL);
    assign w_num  = $signed({1'b0, w_prod}) - NUM_W'(WL_OFF);

    always_comb begin
        n_s1_status  = ST_UNKNOWN;
        n_s1_written = 1'b0;
        n_s1_val     = '0;
        n_s1_inch    = '0;
        n_s1_water   = 1'b0;
        if (r_s0_chan != CH_3) begin
            if (r_s0_board == 1'b0) begin
                n_s1_written = 1'b1;
                case (r_s0_chan)
                    CH_0: begin
                        if (r_s0_cur < SW_LOW) begin
                            n_s1_status = ST_TWO;
                            n_s1_val    = VAL_W'(-ONE_FX);
                        end else if (r_s0_cur <= SW_HIGH) begin
                            n_s1_status = ST_GOOD;
                            n_s1_val    = w_sw_code;
                        end else begin
                            n_s1_status = ST_ONE;
                            n_s1_val    = VAL_W'(SW_OPEN_VAL);
                        end
                    end
                    CH_1: begin
                        // Readings strictly between 1.4 and 1.5 mA land in
                        // the faulty branch along with high readings.
                        if (r_s0_cur <= SW_B_FAULT) begin
                            n_s1_status = ST_TWO;
                            n_s1_val    = w_cur_whole;
                        end else if (r_s0_cur >= SW_B_LOW && r_s0_cur <= SW_HIGH) begin
                            n_s1_status = ST_GOOD;
                            n_s1_val    = w_sw_code;
                        end else begin
                            n_s1_status = ST_ONE;
                            n_s1_val    = w_cur_whole;
                        end
                    end
                    default: begin
                        if (r_s0_volt < PSI_LOW) begin
                            n_s1_status = ST_TWO;
                        end else begin
                            n_s1_status = (r_s0_volt > PSI_HIGH) ? ST_ONE : ST_GOOD;
                            n_s1_val    = VAL_W'(w_psi_x15 >> 2);
                        end
                    end
                endcase
            end else begin
                case (r_s0_chan)
                    CH_0: begin
                        if (r_s0_volt < R33_LOW)       n_s1_status = ST_ONE;
                        else if (r_s0_volt > R33_HIGH) n_s1_status = ST_TWO;
                        else                           n_s1_status = ST_GOOD;
                    end
                    CH_1: begin
                        if (r_s0_volt < R12_LOW)             n_s1_status = ST_ONE;
                        else if (r_s0_volt > R12_HIGH)       n_s1_status = ST_TWO;
                        else if (r_s0_cur <= 0)              n_s1_status = ST_ONE;
                        else if (r_s0_cur > R12_I_HIGH)      n_s1_status = ST_TWO;
                        else                                 n_s1_status = ST_GOOD;
                    end
                    default: begin
                        n_s1_written = 1'b1;
                        if (r_s0_cur < WL_LOW) begin
                            n_s1_status = ST_TWO;
                            n_s1_val    = VAL_W'(WL_MARK_LO);
                            n_s1_inch   = INCH_W'(WL_MARK_LO);
                        end else if (r_s0_cur > WL_HIGH) begin
                            n_s1_status = ST_ONE;
                            n_s1_val    = VAL_W'(WL_MARK_HI);
                            n_s1_inch   = INCH_W'(WL_MARK_HI);
                        end else begin
                            n_s1_status = ST_GOOD;
                            n_s1_water  = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    logic [1:0]               r_s1_status;
    logic                     r_s1_written;
    logic signed [VAL_W-1:0]  r_s1_val;
    logic signed [INCH_W-1:0] r_s1_inch;
    logic                     r_s1_water;
    logic signed [NUM_W-1:0]  r_s1_num;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_status  <= n_s1_status;
            r_s1_written <= n_s1_written;
            r_s1_val     <= n_s1_val;
            r_s1_inch    <= n_s1_inch;
            r_s1_water   <= n_s1_water;
            r_s1_num     <= w_num;
        end
    end

    // Stage 2: depth in whole mm, truncated toward zero.
    logic [NUM_W-2:0]                    w_num_abs;
    logic [MM_OP_W+MM_RECIP_W-1:0]       w_mm_prod;

    assign w_num_abs = r_s1_num[NUM_W-1] ? (NUM_W-1)'(-r_s1_num)
                                         : r_s1_num[NUM_W-2:0];
    assign w_mm_prod = (MM_OP_W+MM_RECIP_W)'(w_num_abs[MM_PRE_SHIFT+MM_OP_W-1:MM_PRE_SHIFT])
                     * (MM_OP_W+MM_RECIP_W)'(MM_RECIP);

    logic [1:0]               r_s2_status;
    logic                     r_s2_written;
    logic signed [VAL_W-1:0]  r_s2_val;
    logic signed [INCH_W-1:0] r_s2_inch;
    logic                     r_s2_water;
    logic                     r_s2_neg;
    logic [MM_W-1:0]          r_s2_mm;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_status  <= r_s1_status;
            r_s2_written <= r_s1_written;
            r_s2_val     <= r_s1_val;
            r_s2_inch    <= r_s1_inch;
            r_s2_water   <= r_s1_water;
            r_s2_neg     <= r_s1_num[NUM_W-1];
            r_s2_mm      <= w_mm_prod[MM_SHIFT+MM_W-1:MM_SHIFT];
        end
    end

    // Stage 3: depth in inches and the result register.
    logic [IN_X_W-1:0]                  w_in_x;
    logic [IN_X_W+IN_RECIP_W-1:0]       w_in_prod;
    logic [IN_MAG_W-1:0]                w_in_mag;
    logic signed [VAL_W-1:0]            w_mm_fx;
    logic signed [INCH_W-1:0]           w_in_fx;
    logic signed [VAL_W-1:0]            n_s3_val;
    logic signed [INCH_W-1:0]           n_s3_inch;

    // mm * 1280 as shift and add.
    assign w_in_x    = (IN_X_W'(r_s2_mm) << 10) + (IN_X_W'(r_s2_mm) << 8);
    assign w_in_prod = (IN_X_W+IN_RECIP_W)'(w_in_x) * (IN_X_W+IN_RECIP_W)'(IN_RECIP);
    assign w_in_mag  = w_in_prod[IN_SHIFT+IN_MAG_W-1:IN_SHIFT];
    assign w_mm_fx   = VAL_W'({r_s2_mm, {FRAC_BITS{1'b0}}});
    assign w_in_fx   = INCH_W'(w_in_mag);

    always_comb begin
        n_s3_val  = r_s2_val;
        n_s3_inch = r_s2_inch;
        if (r_s2_water) begin
            n_s3_val  = r_s2_neg ? -w_mm_fx : w_mm_fx;
            n_s3_inch = r_s2_neg ? -w_in_fx : w_in_fx;
        end
    end

    logic [1:0]               r_s3_status;
    logic                     r_s3_written;
    logic signed [VAL_W-1:0]  r_s3_val;
    logic signed [INCH_W-1:0] r_s3_inch;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_status  <= r_s2_status;
            r_s3_written <= r_s2_written;
            r_s3_val     <= n_s3_val;
            r_s3_inch    <= n_s3_inch;
        end
    end

    assign o_health_status = r_s3_status;
    assign o_value_written = r_s3_written;
    assign o_scaled_value  = r_s3_val;
    assign o_depth_inches  = r_s3_inch;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sch_pkg::*;

    localparam logic   BRD_SWITCH   = 1'b0;   // switches and pressure sensor
    localparam logic   BRD_SUPPLY   = 1'b1;   // supply rails and water level
    localparam longint ONE          = ONE_FX;
    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     RANDOM_COUNT = 1300;

    typedef struct {
        logic [BOARD_W-1:0]       board;
        logic [CHAN_W-1:0]        chan;
        logic signed [CUR_W-1:0]  cur;
        logic [VOLT_W-1:0]        volt;
        bit                       hold;   // present only once all results are back
    } t_reading;

    typedef struct packed {
        logic [1:0]         status;
        logic               written;
        logic [VAL_W-1:0]   val;
        logic [INCH_W-1:0]  inch;
    } t_health;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [BOARD_W-1:0]         i_board_index = '0;
    logic [CHAN_W-1:0]          i_channel_index = '0;
    logic signed [CUR_W-1:0]    i_current_reading = '0;
    logic [VOLT_W-1:0]          i_bus_voltage = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [1:0]                 o_health_status;
    logic                       o_value_written;
    logic signed [VAL_W-1:0]    o_scaled_value;
    logic signed [INCH_W-1:0]   o_depth_inches;

    t_reading readings_q [$];
    t_health  health_q [$];
    logic     in_taken = 1'b0;
    int       mismatches = 0;
    int       readings_sent = 0;
    int       results_checked = 0;
    int       status_seen [4] = '{0, 0, 0, 0};
    int       cycle_count = 0;
    int       burst_left = 1;
    int       gap_left = 0;
    int       ready_mode = 0;
    int       mode_left = 0;
    int       stall_phase = 0;
    int       cur_edges [0:9] = '{0, 256, 358, 384, 896, 1024, 3840, 5376, 7424, 128000};
    int       volt_edges [0:6] = '{256, 793, 896, 1152, 2304, 3840, 8191};

    sensor_channel_health_and_scaling dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_board_index     (i_board_index),
        .i_channel_index   (i_channel_index),
        .i_current_reading (i_current_reading),
        .i_bus_voltage     (i_bus_voltage),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_health_status   (o_health_status),
        .o_value_written   (o_value_written),
        .o_scaled_value    (o_scaled_value),
        .o_depth_inches    (o_depth_inches)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_health predict_health(t_reading r);
        longint  cur;
        longint  volt;
        longint  v;
        longint  inch;
        longint  num;
        longint  mm;
        logic [1:0] st;
        t_health h;
        cur  = longint'(r.cur);
        volt = longint'(r.volt);
        st   = ST_UNKNOWN;
        v    = 0;
        inch = 0;
        h.written = 1'b0;
        if (r.chan != CH_3) begin
            if (r.board == BRD_SWITCH && r.chan == CH_0) begin
                h.written = 1'b1;
                if (cur < ONE) begin
                    st = ST_TWO;
                    v  = -ONE;
                end else if (cur <= 29 * ONE) begin
                    st = ST_GOOD;
                    v  = (cur < 15 * ONE) ? 0 : ONE;
                end else begin
                    st = ST_ONE;
                    v  = 255 * ONE;
                end
            end else if (r.board == BRD_SWITCH && r.chan == CH_1) begin
                // The gap between 1.4 and 1.5 mA falls through to the fault branch.
                h.written = 1'b1;
                if (cur * 10 <= 14 * ONE) begin
                    st = ST_TWO;
                    v  = (cur / ONE) * ONE;
                end else if (cur * 2 >= 3 * ONE && cur <= 29 * ONE) begin
                    st = ST_GOOD;
                    v  = (cur < 15 * ONE) ? 0 : ONE;
                end else begin
                    st = ST_ONE;
                    v  = (cur / ONE) * ONE;
                end
            end else if (r.board == BRD_SWITCH) begin
                h.written = 1'b1;
                if (volt < ONE) begin
                    st = ST_TWO;
                end else begin
                    st = (volt * 2 > 9 * ONE) ? ST_ONE : ST_GOOD;
                    v  = ((volt * 2 - ONE) * 15) / 4;
                end
            end else if (r.chan == CH_0) begin
                if (volt * 10 < 31 * ONE)     st = ST_ONE;
                else if (volt * 2 > 7 * ONE)  st = ST_TWO;
                else                          st = ST_GOOD;
            end else if (r.chan == CH_1) begin
                if (volt < 9 * ONE)           st = ST_ONE;
                else if (volt > 15 * ONE)     st = ST_TWO;
                else if (cur <= 0)            st = ST_ONE;
                else if (cur > 500 * ONE)     st = ST_TWO;
                else                          st = ST_GOOD;
            end else begin
                h.written = 1'b1;
                if (cur * 2 < 7 * ONE) begin
                    st   = ST_TWO;
                    v    = 255 * ONE;
                    inch = 255 * ONE;
                end else if (cur > 21 * ONE) begin
                    st   = ST_ONE;
                    v    = -ONE;
                    inch = -ONE;
                end else begin
                    // Depth in whole mm, then inches on the fraction grid.
                    num  = (cur * 100 - 410 * ONE) * 2940 + 60 * 1582 * ONE;
                    mm   = num / (1582 * ONE);
                    st   = ST_GOOD;
                    v    = mm * ONE;
                    inch = (mm * ONE * 10) / 254;
                end
            end
        end
        h.status = st;
        h.val    = v[VAL_W-1:0];
        h.inch   = inch[INCH_W-1:0];
        return h;
    endfunction

    task automatic add_reading(input logic b, input logic [1:0] c, input int cur,
                               input int volt, input bit hold);
        t_reading r;
        r.board = b;
        r.chan  = c;
        r.cur   = cur[CUR_W-1:0];
        r.volt  = volt[VOLT_W-1:0];
        r.hold  = hold;
        readings_q.push_back(r);
    endtask

    function automatic t_reading random_reading();
        t_reading r;
        int       pick;
        int       cur;
        int       volt;
        r.hold  = 1'b0;
        r.board = 1'($urandom_range(0, 1));
        r.chan  = ($urandom_range(0, 19) == 0) ? CH_3 : 2'($urandom_range(0, 2));
        pick = $urandom_range(0, 9);
        if (pick < 3)
            cur = int'($urandom());
        else if (pick < 7)
            cur = cur_edges[$urandom_range(0, 9)] + int'($urandom_range(0, 6)) - 3;
        else
            cur = int'($urandom_range(0, 8191));
        pick = $urandom_range(0, 9);
        if (pick < 3)
            volt = int'($urandom());
        else if (pick < 7)
            volt = volt_edges[$urandom_range(0, 6)] + int'($urandom_range(0, 6)) - 3;
        else if (pick < 9)
            volt = int'($urandom_range(2304, 3840));
        else
            volt = int'($urandom_range(0, 1300));
        r.cur  = cur[CUR_W-1:0];
        r.volt = volt[VOLT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Sender: bursts of transactions separated by random gaps.
    always @(negedge i_clk) begin
        t_reading nxt;
        logic     drive;
        drive = 1'b0;
        if (i_rst_n && !(i_valid && !in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (readings_q.size() > 0 &&
                         !(readings_q[0].hold && health_q.size() > 0)) begin
                nxt = readings_q.pop_front();
                drive = 1'b1;
                i_board_index     <= nxt.board;
                i_channel_index   <= nxt.chan;
                i_current_reading <= nxt.cur;
                i_bus_voltage     <= nxt.volt;
                if (burst_left > 1) begin
                    burst_left--;
                end else if ($urandom_range(0, 3) == 0) begin
                    burst_left = $urandom_range(40, 120);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = $urandom_range(1, 6);
                end
            end
            i_valid <= drive;
        end
    end

    // Receiver: a stall pattern whose mode is redrawn at random.
    always @(negedge i_clk) begin
        logic rdy;
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 150);
        end
        mode_left--;
        stall_phase++;
        case (ready_mode)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(0, 1));
            2:       rdy = (stall_phase % 4) != 3;
            default: rdy = ($urandom_range(0, 3) == 0);
        endcase
        i_ready <= rdy;
    end

    // Monitor: retire results against predictions, then record new transactions.
    always @(posedge i_clk) begin
        t_reading got_in;
        t_health  want;
        in_taken <= i_valid && o_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (health_q.size() == 0) begin
                    report_mismatch("result transaction with no reading outstanding");
                end else begin
                    want = health_q.pop_front();
                    results_checked++;
                    status_seen[want.status]++;
                    if (o_health_status !== want.status || o_value_written !== want.written ||
                        o_scaled_value !== want.val || o_depth_inches !== want.inch)
                        report_mismatch($sformatf(
                            {"result %0d: got st=%0d wr=%0d val=%0d in=%0d, ",
                             "want st=%0d wr=%0d val=%0d in=%0d"},
                            results_checked, o_health_status, o_value_written,
                            o_scaled_value, o_depth_inches, want.status, want.written,
                            $signed(want.val), $signed(want.inch)));
                end
            end
            if (i_valid && o_ready) begin
                got_in.board = i_board_index;
                got_in.chan  = i_channel_index;
                got_in.cur   = i_current_reading;
                got_in.volt  = i_bus_voltage;
                got_in.hold  = 1'b0;
                health_q.push_back(predict_health(got_in));
                readings_sent++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out with %0d readings pending and %0d results outstanding",
                     readings_q.size(), health_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int n;
        // Window edges on every channel, plus the unknown channel code.
        add_reading(BRD_SWITCH, CH_0, 255, 0, 1'b0);
        add_reading(BRD_SWITCH, CH_0, 256, 0, 1'b0);
        add_reading(BRD_SWITCH, CH_0, 3840, 0, 1'b0);
        add_reading(BRD_SWITCH, CH_0, 7425, 0, 1'b0);
        add_reading(BRD_SWITCH, CH_1, 358, 0, 1'b0);
        add_reading(BRD_SWITCH, CH_1, 359, 0, 1'b0);
        add_reading(BRD_SWITCH, CH_1, 384, 0, 1'b0);
        add_reading(BRD_SWITCH, CH_1, -300, 0, 1'b0);
        add_reading(BRD_SWITCH, CH_2, 0, 255, 1'b0);
        add_reading(BRD_SWITCH, CH_2, 0, 1152, 1'b0);
        add_reading(BRD_SWITCH, CH_2, 0, 1153, 1'b0);
        add_reading(BRD_SWITCH, CH_2, 0, 8191, 1'b0);
        add_reading(BRD_SUPPLY, CH_0, 0, 793, 1'b0);
        add_reading(BRD_SUPPLY, CH_0, 0, 794, 1'b0);
        add_reading(BRD_SUPPLY, CH_0, 0, 897, 1'b0);
        add_reading(BRD_SUPPLY, CH_1, 5, 2303, 1'b0);
        add_reading(BRD_SUPPLY, CH_1, 0, 3840, 1'b0);
        add_reading(BRD_SUPPLY, CH_1, 5, 3841, 1'b0);
        add_reading(BRD_SUPPLY, CH_1, 128001, 2304, 1'b0);
        add_reading(BRD_SUPPLY, CH_2, 895, 0, 1'b0);
        add_reading(BRD_SUPPLY, CH_2, 896, 0, 1'b0);
        add_reading(BRD_SUPPLY, CH_2, 5376, 0, 1'b0);
        add_reading(BRD_SUPPLY, CH_2, 5377, 0, 1'b0);
        add_reading(BRD_SWITCH, CH_3, -262144, 8191, 1'b0);
        add_reading(BRD_SUPPLY, CH_3, 262143, 0, 1'b0);
        n = readings_q.size();
        for (int k = 0; k < RANDOM_COUNT; k++) begin
            readings_q.push_back(random_reading());
            // Drain the pipeline now and then before continuing.
            if (k % 400 == 0)
                readings_q[readings_q.size() - 1].hold = 1'b1;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (readings_q.size() != 0 || i_valid || health_q.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("Covered %0d readings (%0d directed edges, unknown channel included) %s",
                 readings_sent, n, "under bursty input and a stalling receiver.");
        $display({"Results compared: %0d; status good/one/two/unknown ",
                  "%0d/%0d/%0d/%0d; %0d mismatches"},
                 results_checked, status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
